### design/isotp_tx_segmenter_core_macros.svh
// Assertion helpers shared by the segmenter RTL.
// Each expects clk and rst_n in scope.
`ifndef ISOTP_TX_SEGMENTER_CORE_MACROS_SVH
`define ISOTP_TX_SEGMENTER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ISOTP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isotp segmenter: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ISOTP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isotp segmenter: next-cycle check failed");

`endif

### design/isotp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package isotp_pkg;

    // Classic CAN frame size and derived payload room
    localparam int FRAME_BYTES = 8;
    localparam int FF_PAYLOAD  = FRAME_BYTES - 2;
    localparam int CF_PAYLOAD  = FRAME_BYTES - 1;

    // Item modes
    localparam logic MODE_PAYLOAD = 1'b0;
    localparam logic MODE_FC      = 1'b1;

    // PCI frame types (upper nibble of the first frame byte)
    localparam logic [3:0] PCI_SF = 4'h0;
    localparam logic [3:0] PCI_FF = 4'h1;
    localparam logic [3:0] PCI_CF = 4'h2;
    localparam logic [3:0] PCI_FC = 4'h3;

    // STmin encoding of 100 us units
    localparam logic [3:0] STMIN_US_HI  = 4'hF;
    localparam logic [3:0] STMIN_US_MAX = 4'd9;

    localparam int MAX_BEATS = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       done;
    } seg_beat_t;

    typedef struct packed {
        seg_beat_t [MAX_BEATS-1:0] beat;
        logic [1:0]                count;
    } seg_result_t;

endpackage
`default_nettype wire

### design/isotp_seg.sv
`timescale 1ns / 1ps
`default_nettype none
module isotp_seg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic                 mode,
    input  wire logic [7:0]           payload_byte,
    input  wire logic [11:0]          message_length,
    input  wire logic [1:0]           fc_status,
    input  wire logic [7:0]           fc_block_size,
    input  wire logic [6:0]           fc_sep_ms,
    input  wire logic [3:0]           fc_sep_100us,
    output isotp_pkg::seg_result_t    result
);
    import isotp_pkg::*;

    logic        in_msg_reg,  in_msg_next;
    logic [11:0] total_reg,   total_next;
    logic [11:0] taken_reg,   taken_next;
    logic [2:0]  fill_reg,    fill_next;
    logic [3:0]  seq_reg,     seq_next;

    logic [11:0] tl, bt, bt_inc;
    logic [2:0]  ff, ff_inc, limit;
    logic [3:0]  sq, sq_inc;
    logic        single;
    logic [1:0]  hdr_cnt;
    seg_beat_t   h0, h1, dbeat;
    logic [7:0]  sep;

    always_comb
    begin
        in_msg_next = in_msg_reg;
        total_next  = total_reg;
        taken_next  = taken_reg;
        fill_next   = fill_reg;
        seq_next    = seq_reg;
        result      = '0;
        h0          = '0;
        h1          = '0;
        dbeat       = '0;
        hdr_cnt     = 2'd0;

        // Fresh message starts from a clean slate with the sampled length
        tl     = in_msg_reg ? total_reg : message_length;
        bt     = in_msg_reg ? taken_reg : 12'd0;
        ff     = in_msg_reg ? fill_reg  : 3'd0;
        sq     = in_msg_reg ? seq_reg   : 4'd0;
        sq_inc = sq + 4'd1;
        bt_inc = bt + 12'd1;
        ff_inc = ff + 3'd1;
        single = (tl < 12'(FRAME_BYTES));

        if (fc_sep_100us != 4'd0)
            sep = {STMIN_US_HI, (fc_sep_100us > STMIN_US_MAX) ? STMIN_US_MAX : fc_sep_100us};
        else
            sep = {1'b0, fc_sep_ms};

        if (single)
            limit = 3'(CF_PAYLOAD);
        else if (bt < 12'(FF_PAYLOAD))
            limit = 3'(FF_PAYLOAD);
        else
            limit = 3'(CF_PAYLOAD);

        if (mode == MODE_FC) begin
            result.beat[0] = '{data: {PCI_FC, 2'b00, fc_status}, first: 1'b1,
                               last: 1'b0, done: 1'b0};
            result.beat[1] = '{data: fc_block_size, first: 1'b0, last: 1'b0, done: 1'b0};
            result.beat[2] = '{data: sep, first: 1'b0, last: 1'b1, done: 1'b1};
            result.count   = 2'd3;
        end else if (in_msg_reg || message_length != 12'd0) begin
            in_msg_next = 1'b1;
            total_next  = tl;
            seq_next    = sq;

            if (bt == 12'd0) begin
                if (single) begin
                    h0      = '{data: {PCI_SF, tl[3:0]}, first: 1'b1, last: 1'b0, done: 1'b0};
                    hdr_cnt = 2'd1;
                end else begin
                    h0      = '{data: {PCI_FF, tl[11:8]}, first: 1'b1, last: 1'b0, done: 1'b0};
                    h1      = '{data: tl[7:0], first: 1'b0, last: 1'b0, done: 1'b0};
                    hdr_cnt = 2'd2;
                end
            end else if (ff == 3'd0) begin
                seq_next = sq_inc;
                h0       = '{data: {PCI_CF, sq_inc}, first: 1'b1, last: 1'b0, done: 1'b0};
                hdr_cnt  = 2'd1;
            end

            taken_next = bt_inc;
            fill_next  = ff_inc;
            dbeat.data = payload_byte;
            if (bt_inc >= tl) begin
                // Message complete: close the frame and return to idle
                dbeat.last  = 1'b1;
                dbeat.done  = 1'b1;
                in_msg_next = 1'b0;
                fill_next   = 3'd0;
            end else if (ff_inc >= limit) begin
                dbeat.last = 1'b1;
                fill_next  = 3'd0;
            end

            case (hdr_cnt)
                2'd0:
                begin
                    result.beat[0] = dbeat;
                end
                2'd1:
                begin
                    result.beat[0] = h0;
                    result.beat[1] = dbeat;
                end
                2'd2:
                begin
                    result.beat[0] = h0;
                    result.beat[1] = h1;
                    result.beat[2] = dbeat;
                end
                default:
                begin
                    result.beat[0] = dbeat;
                end
            endcase
            result.count = hdr_cnt + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_msg_reg <= 1'b0;
            total_reg  <= 12'd0;
            taken_reg  <= 12'd0;
            fill_reg   <= 3'd0;
            seq_reg    <= 4'd0;
        end else if (in_fire) begin
            in_msg_reg <= in_msg_next;
            total_reg  <= total_next;
            taken_reg  <= taken_next;
            fill_reg   <= fill_next;
            seq_reg    <= seq_next;
        end
    end

endmodule
`default_nettype wire

### design/isotp_obuf.sv
`timescale 1ns / 1ps
`default_nettype none
module isotp_obuf (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_fire,
    input  wire isotp_pkg::seg_result_t result,
    output logic                       load_ok,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 frame_byte,
    output logic                       frame_first,
    output logic                       frame_last,
    output logic                       message_done
);
    import isotp_pkg::*;

    seg_beat_t [MAX_BEATS-1:0] ent_reg;
    logic [1:0]                rem_reg;
    logic [1:0]                idx_reg;
    seg_beat_t                 cur;
    logic                      out_fire;

    assign out_valid = (rem_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;
    // Take a new item once the buffer drains this cycle
    assign load_ok   = (rem_reg == 2'd0) || (rem_reg == 2'd1 && out_ready);

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = ent_reg[0];
            2'd1:    cur = ent_reg[1];
            2'd2:    cur = ent_reg[2];
            default: cur = ent_reg[0];
        endcase
    end

    assign frame_byte   = cur.data;
    assign frame_first  = cur.first;
    assign frame_last   = cur.last;
    assign message_done = cur.done;

    always_ff @(posedge clk)
    begin
        if (in_fire)
            ent_reg <= result.beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (in_fire) begin
            rem_reg <= result.count;
            idx_reg <= 2'd0;
        end else if (out_fire) begin
            rem_reg <= rem_reg - 2'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule
`default_nettype wire

### design/isotp_tx_segmenter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------------
// input    | in_valid / in_ready | mode, payload_byte, message_length, fc_* fields
// output   | out_valid/out_ready | frame_byte, frame_first, frame_last, message_done
//
// Each input beat yields zero to three frame bytes, computed combinationally from
// the input ports and the segmentation state and loaded into a three-entry result buffer,
// which sends one byte per cycle while out_ready is high. A payload beat
// mid-frame yields one byte, a frame start two or three, a flow-control beat three.
// in_ready rises once the buffer holds nothing or its last byte leaves now.
// Reset (rst_n low) returns to idle with an empty buffer; output stalls hold
// the buffer and block further input beats.
module isotp_tx_segmenter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [11:0] message_length,
    input  wire logic [1:0]  fc_status,
    input  wire logic [7:0]  fc_block_size,
    input  wire logic [6:0]  fc_sep_ms,
    input  wire logic [3:0]  fc_sep_100us,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       frame_byte,
    output logic             frame_first,
    output logic             frame_last,
    output logic             message_done
);
    import isotp_pkg::*;

    `include "isotp_tx_segmenter_core_macros.svh"

    seg_result_t result;
    logic        in_fire;

    assign in_fire = in_valid && in_ready;

    // Segmentation state and per-beat frame byte generation
    isotp_seg u_seg (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .mode           (mode),
        .payload_byte   (payload_byte),
        .message_length (message_length),
        .fc_status      (fc_status),
        .fc_block_size  (fc_block_size),
        .fc_sep_ms      (fc_sep_ms),
        .fc_sep_100us   (fc_sep_100us),
        .result         (result)
    );

    // Result buffer: hold up to three bytes and drain one per cycle while out_ready is high
    isotp_obuf u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .result       (result),
        .load_ok      (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_byte   (frame_byte),
        .frame_first  (frame_first),
        .frame_last   (frame_last),
        .message_done (message_done)
    );

    // A message end always closes a frame
    `ISOTP_ASSERT_IMP(a_done_closes_frame, out_valid && message_done, frame_last)
    // New input only when the buffer is empty or a byte leaves at this edge
    `ISOTP_ASSERT_IMP(a_no_overrun, in_fire, !out_valid || (out_ready && frame_last) || out_ready)
    // A flow-control beat starts an FC frame in the next cycle
    `ISOTP_ASSERT_NXT(a_fc_start, in_fire && mode == MODE_FC,
        out_valid && frame_first && frame_byte[7:4] == PCI_FC)

endmodule
`default_nettype wire

### test/isotp_seg_checker.sv
`timescale 1ns / 1ps
module isotp_seg_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  payload_byte,
    input  logic [11:0] message_length,
    input  logic [1:0]  fc_status,
    input  logic [7:0]  fc_block_size,
    input  logic [6:0]  fc_sep_ms,
    input  logic [3:0]  fc_sep_100us,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  frame_byte,
    input  logic        frame_first,
    input  logic        frame_last,
    input  logic        message_done,
    output int          mismatches,
    output int          bytes_owed
);
    import isotp_pkg::*;

    // Segmentation state of the predictor
    logic        msg_open;
    logic [11:0] msg_len;
    logic [11:0] taken;
    logic [2:0]  fill;
    logic [3:0]  seq_num;

    seg_beat_t   owed_q[$];
    int          bad_count = 0;

    assign mismatches = bad_count;

    function automatic seg_beat_t make_beat(logic [7:0] d, logic f, logic l, logic dn);
        seg_beat_t b;
        b.data  = d;
        b.first = f;
        b.last  = l;
        b.done  = dn;
        return b;
    endfunction

    task automatic segment_item(
        input logic        m,
        input logic [7:0]  data,
        input logic [11:0] len,
        input logic [1:0]  st,
        input logic [7:0]  bs,
        input logic [6:0]  ms,
        input logic [3:0]  us
    );
        logic       single;
        int         room;
        logic [7:0] stmin;
        if (m == MODE_FC) begin
            // Saturate the 100 us count, else fall back to milliseconds
            if (us != 4'd0)
                stmin = {STMIN_US_HI, (us > STMIN_US_MAX) ? STMIN_US_MAX : us};
            else
                stmin = {1'b0, ms};
            owed_q.push_back(make_beat({PCI_FC, 2'b00, st}, 1'b1, 1'b0, 1'b0));
            owed_q.push_back(make_beat(bs, 1'b0, 1'b0, 1'b0));
            owed_q.push_back(make_beat(stmin, 1'b0, 1'b1, 1'b1));
            return;
        end
        if (!msg_open) begin
            if (len == 12'd0)
                return;
            msg_open = 1'b1;
            msg_len  = len;
            taken    = '0;
            fill     = '0;
            seq_num  = '0;
        end
        single = (msg_len < FRAME_BYTES);
        if (taken == 12'd0) begin
            if (single) begin
                owed_q.push_back(make_beat({PCI_SF, msg_len[3:0]}, 1'b1, 1'b0, 1'b0));
            end
            else begin
                owed_q.push_back(make_beat({PCI_FF, msg_len[11:8]}, 1'b1, 1'b0, 1'b0));
                owed_q.push_back(make_beat(msg_len[7:0], 1'b0, 1'b0, 1'b0));
            end
        end
        else if (fill == 3'd0) begin
            seq_num = seq_num + 4'd1;
            owed_q.push_back(make_beat({PCI_CF, seq_num}, 1'b1, 1'b0, 1'b0));
        end
        if (single)
            room = CF_PAYLOAD;
        else if (taken < FF_PAYLOAD)
            room = FF_PAYLOAD;
        else
            room = CF_PAYLOAD;
        taken = taken + 12'd1;
        fill  = fill + 3'd1;
        if (taken >= msg_len) begin
            owed_q.push_back(make_beat(data, 1'b0, 1'b1, 1'b1));
            msg_open = 1'b0;
            fill     = '0;
        end
        else if (fill >= room) begin
            owed_q.push_back(make_beat(data, 1'b0, 1'b1, 1'b0));
            fill = '0;
        end
        else begin
            owed_q.push_back(make_beat(data, 1'b0, 1'b0, 1'b0));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        seg_beat_t want;
        if (!rst_n) begin
            msg_open = 1'b0;
            msg_len  = '0;
            taken    = '0;
            fill     = '0;
            seq_num  = '0;
            owed_q.delete();
        end
        else begin
            if (in_valid && in_ready)
                segment_item(mode, payload_byte, message_length, fc_status,
                             fc_block_size, fc_sep_ms, fc_sep_100us);
            if (out_valid && out_ready) begin
                if (owed_q.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: unexpected beat byte %02h first %0b last %0b done %0b",
                                 $time, frame_byte, frame_first, frame_last, message_done);
                end
                else begin
                    want = owed_q.pop_front();
                    if (want.data !== frame_byte || want.first !== frame_first ||
                        want.last !== frame_last || want.done !== message_done) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $display("%0t: beat mismatch: expected byte %02h first %0b last %0b done %0b",
                                     $time, want.data, want.first, want.last, want.done);
                            $display("    got byte %02h first %0b last %0b done %0b",
                                     frame_byte, frame_first, frame_last, message_done);
                        end
                    end
                end
            end
        end
        bytes_owed = owed_q.size();
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
    import isotp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [7:0]  payload_byte;
    logic [11:0] message_length;
    logic [1:0]  fc_status;
    logic [7:0]  fc_block_size;
    logic [6:0]  fc_sep_ms;
    logic [3:0]  fc_sep_100us;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  frame_byte;
    logic        frame_first;
    logic        frame_last;
    logic        message_done;

    int fail_count;
    int bytes_owed;

    // Sender pacing: beats left in the current burst, and beats accepted so far
    int burst_left = 1;
    int items_done = 0;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_BURSTY, SINK_PERIODIC} sink_style_t;

    isotp_tx_segmenter_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .payload_byte   (payload_byte),
        .message_length (message_length),
        .fc_status      (fc_status),
        .fc_block_size  (fc_block_size),
        .fc_sep_ms      (fc_sep_ms),
        .fc_sep_100us   (fc_sep_100us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_byte     (frame_byte),
        .frame_first    (frame_first),
        .frame_last     (frame_last),
        .message_done   (message_done)
    );

    // Predicts and compares every frame byte; only the counts come back here
    isotp_seg_checker check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .payload_byte   (payload_byte),
        .message_length (message_length),
        .fc_status      (fc_status),
        .fc_block_size  (fc_block_size),
        .fc_sep_ms      (fc_sep_ms),
        .fc_sep_100us   (fc_sep_100us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_byte     (frame_byte),
        .frame_first    (frame_first),
        .frame_last     (frame_last),
        .message_done   (message_done),
        .mismatches     (fail_count),
        .bytes_owed     (bytes_owed)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: switch between stall styles at random so that
    // stalls land on PCI bytes, payload bytes and flow-control frames alike,
    // with open stretches where every beat drains at full rate.
    initial begin : sink
        sink_style_t style;
        int          phase_left;
        int          hold;
        out_ready  = 1'b0;
        style      = SINK_OPEN;
        phase_left = 0;
        hold       = 0;
        forever begin
            @(negedge clk);
            if (phase_left == 0) begin
                style      = sink_style_t'($urandom_range(0, 3));
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            case (style)
                SINK_OPEN:   out_ready <= 1'b1;
                SINK_RANDOM: out_ready <= ($urandom_range(0, 9) >= 3);
                SINK_BURSTY:
                begin
                    if (hold > 0) begin
                        hold--;
                        out_ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 5) == 0) begin
                        hold = $urandom_range(1, 8);
                        out_ready <= 1'b0;
                    end
                    else begin
                        out_ready <= 1'b1;
                    end
                end
                default:     out_ready <= (phase_left % 3 == 0);
            endcase
        end
    end

    // Present one beat at the falling edge and hold it until the block takes it.
    // Valid stays high into the next beat unless the burst ends here with a gap.
    task automatic offer(
        input logic        m,
        input logic [7:0]  b,
        input logic [11:0] len,
        input logic [1:0]  st,
        input logic [7:0]  bs,
        input logic [6:0]  ms,
        input logic [3:0]  us
    );
        int gap;
        @(negedge clk);
        mode           <= m;
        payload_byte   <= b;
        message_length <= len;
        fc_status      <= st;
        fc_block_size  <= bs;
        fc_sep_ms      <= ms;
        fc_sep_100us   <= us;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_done++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                // Drop valid and scramble the idle payload during the gap
                @(negedge clk);
                in_valid       <= 1'b0;
                mode           <= 1'($urandom_range(0, 1));
                payload_byte   <= 8'($urandom_range(0, 255));
                message_length <= 12'($urandom_range(0, 4095));
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Payload beat; the flow-control fields carry noise that must be ignored
    task automatic send_byte(input logic [7:0] b, input logic [11:0] len);
        offer(MODE_PAYLOAD, b, len, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
    endtask

    // Flow-control beat; payload and length carry noise that must be ignored
    task automatic send_fc(input logic [1:0] st, input logic [7:0] bs,
                           input logic [6:0] ms, input logic [3:0] us);
        offer(MODE_FC, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
              st, bs, ms, us);
    endtask

    task automatic send_random_fc();
        logic [3:0] us;
        us = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
        send_fc(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                7'($urandom_range(0, 127)), us);
    endtask

    // Whole message with random bytes; length is only honored on the first byte,
    // so later beats carry any length at all. Flow control may cut in between.
    task automatic send_message(input int len, input int fc_pct);
        int i;
        for (i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)),
                      (i == 0) ? 12'(len) : 12'($urandom_range(0, 4095)));
            if (i + 1 < len && $urandom_range(0, 99) < fc_pct)
                send_random_fc();
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(1, 7);
        else if (r < 80)
            return $urandom_range(8, 40);
        else if (r < 90)
            return $urandom_range(41, 99);
        else
            return $urandom_range(100, 140);   // the sequence wraps from 112 bytes on
    endfunction

    initial begin : stim
        int i;
        int r;
        int len;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_PAYLOAD;
        payload_byte   = '0;
        message_length = '0;
        fc_status      = '0;
        fc_block_size  = '0;
        fc_sep_ms      = '0;
        fc_sep_100us   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Zero length while idle: no frame, state untouched
        send_byte(8'hA5, 12'd0);
        // Shortest single frames, payload extremes
        send_byte(8'hFF, 12'd1);
        send_byte(8'h00, 12'd1);
        // Flow control: every status (reserved one too), STmin in ms and
        // in 100 us units below, at and above saturation
        send_fc(2'd0, 8'd0,   7'd0,   4'd0);
        send_fc(2'd1, 8'd255, 7'd127, 4'd0);
        send_fc(2'd2, 8'h5A,  7'd5,   4'd15);
        send_fc(2'd3, 8'd1,   7'd127, 4'd9);
        send_fc(2'd0, 8'h81,  7'd64,  4'd1);
        // Longest single frame; length ignored mid-message, flow control cuts in
        send_byte(8'h11, 12'd7);
        send_byte(8'h22, 12'd0);
        send_byte(8'h33, 12'd4095);
        send_fc(2'd1, 8'd4, 7'd20, 4'd0);
        send_byte(8'h44, 12'd1);
        send_byte(8'h55, 12'd0);
        send_byte(8'h66, 12'd2);
        send_byte(8'h77, 12'd7);
        // Shortest segmented message: first frame plus a two-byte consecutive frame
        send_byte(8'h80, 12'd8);
        for (i = 1; i < 8; i++)
            send_byte(8'(8'h80 + i), 12'd4095);

        // Random traffic: mostly well-formed messages, some bare flow control
        // and ignored zero-length bytes as noise
        while (items_done < 410) begin
            r = $urandom_range(0, 99);
            if (r < 6)
                send_byte(8'($urandom_range(0, 255)), 12'd0);
            else if (r < 16)
                send_random_fc();
            else begin
                // Trim the last message so the run stays near its item budget
                len = pick_length();
                if (len > 410 - items_done)
                    len = 410 - items_done;
                send_message(len, 8);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray beat
        while (bytes_owed != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
